### src/asa_pkg.sv
package asa_pkg;

	// Width of the offset arithmetic. All offsets, sizes and alignments wrap at this width.
	localparam int ADDR_BITS = 32;
	// Width of the word-wide payload and register fields at the ports.
	localparam int WORD_BITS = 32;
	localparam int REG_IDX_W = 2;
	localparam int PADDR_W   = REG_IDX_W + 2;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [ADDR_BITS:0]   addr_carry_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic {
		KIND_ALLOC   = 1'b0,
		KIND_RELEASE = 1'b1
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_REGION_BASE = 2'd0,
		REG_REGION_SIZE = 2'd1,
		REG_REAL_MODE   = 2'd2,
		REG_STATE_MODE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		word_t region_base;
		word_t region_size;
		logic  real_mode;
		logic  state_mode;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		word_t request_size;
		word_t request_alignment;
		word_t restore_offset;
		word_t check_offset;
	} req_t;

	typedef struct packed {
		logic  ok;
		word_t granted_address;
		word_t token_restore;
		word_t token_check;
		word_t peak_alignment;
		word_t peak_offset;
		logic  locked;
	} res_t;

	// Bring a port field into the offset width, and back out again.
	function automatic addr_t to_addr(word_t v);
		return addr_t'(v);
	endfunction

	function automatic word_t to_word(addr_t v);
		return word_t'(v);
	endfunction

endpackage

### src/aligned_stack_allocator.sv
// Aligned stack (bump) allocator.
// Request channel: one word per request, taken when in_valid is high and
// in_stall is low. kind selects allocate or release; an allocate rounds the
// running top offset up to request_alignment and adds request_size, a
// release puts the top back to restore_offset when check_offset matches.
// Result channel: exactly one word per request, in order, taken when
// out_valid is high and out_stall is low.
// A request waits in the input register, then its result word in the result
// register, which drives out_valid. In the input register a single pass of
// logic (one rounding add, one size add, a limit compare) computes the
// result and the next allocator state; both are registered when the result
// register can take a new word. Without stalls, throughput is one word per
// cycle: the state update for one request is finished before the following
// request reaches the engine. When the receiver stalls, the result register
// holds its word and the input register keeps one more request; only then
// is in_stall raised. Reset clears the top offset and the peaks, unlocks
// the allocator, sets region_base and region_size to zero, real_mode to
// one, state_mode to zero. Configuration goes through the APB port, to be
// written by the user only while idle; the block does not enforce that.
module aligned_stack_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [asa_pkg::PADDR_W-1:0] paddr,
	input  asa_pkg::word_t              pwdata,
	output asa_pkg::word_t              prdata,
	output logic                        pready,
	// Request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  asa_pkg::word_t              request_size,
	input  asa_pkg::word_t              request_alignment,
	input  asa_pkg::word_t              restore_offset,
	input  asa_pkg::word_t              check_offset,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output asa_pkg::word_t              granted_address,
	output asa_pkg::word_t              token_restore,
	output asa_pkg::word_t              token_check,
	output asa_pkg::word_t              peak_alignment,
	output asa_pkg::word_t              peak_offset,
	output logic                        locked
);
	import asa_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic advance;
	logic fire;

	asa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register can take a new word when it is empty or its word
	// leaves in this cycle. The engine commits its state change only then.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (!in_stall && in_valid) begin
			req_s1.kind              <= kind_t'(kind);
			req_s1.request_size      <= request_size;
			req_s1.request_alignment <= request_alignment;
			req_s1.restore_offset    <= restore_offset;
			req_s1.check_offset      <= check_offset;
		end
	end

	asa_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.req    (req_s1),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = res_q.ok;
	assign granted_address = res_q.granted_address;
	assign token_restore   = res_q.token_restore;
	assign token_check     = res_q.token_check;
	assign peak_alignment  = res_q.peak_alignment;
	assign peak_offset     = res_q.peak_offset;
	assign locked          = res_q.locked;

endmodule

### src/asa_regs.sv
module asa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [asa_pkg::PADDR_W-1:0]  paddr,
	input  asa_pkg::word_t               pwdata,
	output asa_pkg::word_t               prdata,
	output logic                         pready,
	output asa_pkg::cfg_t                cfg
);
	import asa_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_base <= '0;
			cfg_q.region_size <= '0;
			cfg_q.real_mode   <= 1'b1;
			cfg_q.state_mode  <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_REGION_BASE: cfg_q.region_base <= pwdata;
				REG_REGION_SIZE: cfg_q.region_size <= pwdata;
				REG_REAL_MODE:   cfg_q.real_mode   <= pwdata[0];
				REG_STATE_MODE:  cfg_q.state_mode  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_REGION_BASE: prdata = cfg_q.region_base;
			REG_REGION_SIZE: prdata = cfg_q.region_size;
			REG_REAL_MODE:   prdata = word_t'(cfg_q.real_mode);
			REG_STATE_MODE:  prdata = word_t'(cfg_q.state_mode);
		endcase
	end

endmodule

### src/asa_engine.sv
module asa_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  asa_pkg::cfg_t cfg,
	input  logic          fire,
	input  asa_pkg::req_t req,
	output asa_pkg::res_t res
);
	import asa_pkg::*;

	addr_t       top_q;
	logic        valid_q;
	addr_t       max_align_q;
	addr_t       max_offset_q;

	addr_t       top_d;
	logic        valid_d;
	addr_t       max_align_d;
	addr_t       max_offset_d;

	addr_t       size;
	addr_t       align;
	addr_t       base;
	addr_t       limit;
	addr_t       amask;
	addr_t       aligned;
	addr_t       nxt;
	addr_carry_t sum_round;
	addr_carry_t sum_size;
	logic        pow2;
	logic        fits;
	logic        alloc_ok;
	logic        match;

	always_comb begin
		size      = to_addr(req.request_size);
		align     = to_addr(req.request_alignment);
		base      = to_addr(cfg.region_base);
		limit     = to_addr(cfg.region_size);
		amask     = align - addr_t'(1);
		pow2      = (align != '0) && ((align & amask) == '0);
		// Round up; a carry out of the top bit means the rounding overflowed.
		sum_round = {1'b0, top_q} + {1'b0, amask};
		aligned   = sum_round[ADDR_BITS-1:0] & ~amask;
		sum_size  = {1'b0, aligned} + {1'b0, size};
		nxt       = sum_size[ADDR_BITS-1:0];
		fits      = !cfg.real_mode || ((nxt <= limit) && ((base & amask) == '0));
		alloc_ok  = valid_q && pow2 && !sum_round[ADDR_BITS] && !sum_size[ADDR_BITS] && fits;
		match     = (top_q == to_addr(req.check_offset));

		top_d        = top_q;
		valid_d      = valid_q;
		max_align_d  = max_align_q;
		max_offset_d = max_offset_q;
		res          = '0;

		unique case (req.kind)
			KIND_ALLOC: begin
				if (alloc_ok) begin
					top_d = nxt;
					if (align > max_align_q) max_align_d = align;
					if (nxt > max_offset_q) max_offset_d = nxt;
					if (!cfg.state_mode) begin
						res.token_restore = to_word(top_q);
						res.token_check   = to_word(nxt);
					end
					if (cfg.real_mode) res.granted_address = to_word(base + aligned);
					res.ok = 1'b1;
				end
			end
			KIND_RELEASE: begin
				if (match) begin
					top_d  = to_addr(req.restore_offset);
					res.ok = 1'b1;
				end else begin
					valid_d = 1'b0;
				end
			end
		endcase

		res.peak_alignment = to_word(max_align_d);
		res.peak_offset    = to_word(max_offset_d);
		res.locked         = !valid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			valid_q      <= 1'b1;
			max_align_q  <= '0;
			max_offset_q <= '0;
		end else if (fire) begin
			top_q        <= top_d;
			valid_q      <= valid_d;
			max_align_q  <= max_align_d;
			max_offset_q <= max_offset_d;
		end
	end

`ifndef SYNTH
	// Once locked, only a reset clears the lock.
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |=> !valid_q)
		else $error("allocator lock cleared without reset");

	// No allocation is granted while locked.
	a_no_grant_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.kind == KIND_ALLOC && !valid_q) |-> !res.ok)
		else $error("allocation granted while locked");

	// The peaks never fall.
	a_peaks_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (max_align_q >= $past(max_align_q)) && (max_offset_q >= $past(max_offset_q)))
		else $error("peak value decreased");

	// A granted allocation leaves the top at its new end offset.
	a_grant_moves_top: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.kind == KIND_ALLOC && res.ok) |=> top_q == $past(nxt))
		else $error("top offset does not follow granted allocation");

	// A failed allocation leaves the state alone.
	a_refuse_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.kind == KIND_ALLOC && !res.ok) |=>
			$stable(top_q) && $stable(max_align_q) && $stable(max_offset_q))
		else $error("refused allocation changed state");
`endif

endmodule

### tb/sv/tb_aligned_stack_allocator.sv
// Testbench for the aligned stack allocator.
//
// A behavioral copy of the allocator state (top offset, lock flag, peaks and
// the four registers) runs beside the block. Every request word taken on the
// input channel is pushed through that copy, and the word it predicts is
// queued. Each word taken on the result channel is compared field by field
// against the oldest queued prediction.
module tb_aligned_stack_allocator;
	import asa_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	word_t                pwdata;
	word_t                prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	word_t                request_size;
	word_t                request_alignment;
	word_t                restore_offset;
	word_t                check_offset;
	logic                 out_valid;
	logic                 out_stall;
	logic                 ok;
	word_t                granted_address;
	word_t                token_restore;
	word_t                token_check;
	word_t                peak_alignment;
	word_t                peak_offset;
	logic                 locked;

	aligned_stack_allocator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.request_size      (request_size),
		.request_alignment (request_alignment),
		.restore_offset    (restore_offset),
		.check_offset      (check_offset),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.ok                (ok),
		.granted_address   (granted_address),
		.token_restore     (token_restore),
		.token_check       (token_check),
		.peak_alignment    (peak_alignment),
		.peak_offset       (peak_offset),
		.locked            (locked)
	);

	// Allocator state as the block should hold it, starting from reset values.
	cfg_t  m_cfg        = '{32'd0, 32'd0, 1'b1, 1'b0};
	addr_t m_top        = '0;
	logic  m_unlocked   = 1'b1;
	addr_t m_peak_align = '0;
	addr_t m_peak_off   = '0;

	// Predicted result words, oldest first.
	res_t  expected_grants[$];
	// Offsets in front of successful allocations, so releases can unwind in
	// stack order.
	addr_t rewind_points[$];

	int    errors        = 0;
	int    words_sent    = 0;
	int    words_checked = 0;
	int    reg_writes    = 0;
	int    cycle_count   = 0;
	// Random gaps on the request side and random stalls on the result side.
	bit    tx_idle       = 1'b1;
	bit    rx_idle       = 1'b1;
	// Length of a long receiver hold-off, picked up by the result sink.
	int    rx_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that hangs ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// Works out the result word for one request and advances the state copy.
	// An allocate rounds the top up, adds the size, and is refused without any
	// state change when locked, when the alignment is not a power of two, when
	// either addition carries out, or (in real mode) when the new top passes
	// the region or the base is not aligned. A release matches the top against
	// the check offset and locks the allocator on a mismatch.
	function automatic res_t grant_for(req_t r);
		res_t        g;
		addr_t       amask;
		addr_t       aligned;
		addr_t       new_top;
		addr_carry_t sum;
		logic        fits;
		g       = '0;
		aligned = '0;
		new_top = '0;
		if (r.kind == KIND_ALLOC) begin
			amask = addr_t'(r.request_alignment) - 1'b1;
			fits  = m_unlocked && r.request_alignment != 0
				&& (r.request_alignment & amask) == 0;
			if (fits) begin
				sum     = {1'b0, m_top} + {1'b0, amask};
				fits    = !sum[ADDR_BITS];
				aligned = sum[ADDR_BITS-1:0] & ~amask;
			end
			if (fits) begin
				sum     = {1'b0, aligned} + {1'b0, r.request_size};
				fits    = !sum[ADDR_BITS];
				new_top = sum[ADDR_BITS-1:0];
			end
			if (fits && m_cfg.real_mode)
				fits = new_top <= m_cfg.region_size && (m_cfg.region_base & amask) == 0;
			if (fits) begin
				if (!m_cfg.state_mode) begin
					g.token_restore = m_top;
					g.token_check   = new_top;
				end
				if (m_cfg.real_mode)
					g.granted_address = m_cfg.region_base + aligned;
				if (r.request_alignment > m_peak_align)
					m_peak_align = r.request_alignment;
				if (new_top > m_peak_off)
					m_peak_off = new_top;
				m_top = new_top;
				g.ok  = 1'b1;
			end
		end else if (m_top == r.check_offset) begin
			// A match restores the top even while locked; the lock stays.
			m_top = r.restore_offset;
			g.ok  = 1'b1;
		end else begin
			m_unlocked = 1'b0;
		end
		g.peak_alignment = m_peak_align;
		g.peak_offset    = m_peak_off;
		g.locked         = !m_unlocked;
		return g;
	endfunction

	function automatic req_t alloc_req(word_t size, word_t align);
		req_t r;
		r.kind              = KIND_ALLOC;
		r.request_size      = size;
		r.request_alignment = align;
		r.restore_offset    = $urandom();
		r.check_offset      = $urandom();
		return r;
	endfunction

	function automatic req_t release_req(word_t restore, word_t check);
		req_t r;
		r.kind              = KIND_RELEASE;
		r.request_size      = $urandom();
		r.request_alignment = $urandom();
		r.restore_offset    = restore;
		r.check_offset      = check;
		return r;
	endfunction

	// Mostly well-formed traffic: small power-of-two allocations and releases
	// that match the current top, either unwinding the last allocation or
	// jumping the top to an arbitrary offset. The rest are raw random
	// allocations, which are almost always refused.
	function automatic req_t random_request();
		req_t r;
		int   roll;
		r    = alloc_req($urandom(), $urandom());
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			r.request_size = ($urandom_range(0, 7) == 0) ?
				$urandom() >> $urandom_range(0, 31) : $urandom_range(0, 64);
			r.request_alignment = 32'd1 << (($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 31) : $urandom_range(0, 6));
		end else if (roll < 85) begin
			r = release_req(0, m_top);
			if (rewind_points.size() > 0)
				r.restore_offset = rewind_points.pop_back();
		end else if (roll < 93) begin
			r = release_req($urandom(), m_top);
		end
		return r;
	endfunction

	// Offers one request word after a random gap and holds it until taken.
	// Valid stays high from one word to the next when there is no gap.
	task automatic send_word(req_t r);
		int    gap;
		addr_t prev_top;
		res_t  g;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		kind              <= r.kind;
		request_size      <= r.request_size;
		request_alignment <= r.request_alignment;
		restore_offset    <= r.restore_offset;
		check_offset      <= r.check_offset;
		do @(posedge clk); while (in_stall);
		prev_top = m_top;
		g = grant_for(r);
		if (g.ok && r.kind == KIND_ALLOC)
			rewind_points.push_back(prev_top);
		expected_grants.push_back(g);
		words_sent++;
	endtask

	// Drops valid and waits until every predicted word has come back, then
	// idles on the clock to let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the data
	// at the edge that ends the access cycle.
	task automatic cfg_write(reg_idx_t idx, word_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_REGION_BASE: m_cfg.region_base = value;
			REG_REGION_SIZE: m_cfg.region_size = value;
			REG_REAL_MODE:   m_cfg.real_mode   = value[0];
			REG_STATE_MODE:  m_cfg.state_mode  = value[0];
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic cfg_all(word_t base, word_t size, logic real_m, logic state_m);
		cfg_write(REG_REGION_BASE, base);
		cfg_write(REG_REGION_SIZE, size);
		cfg_write(REG_REAL_MODE, {31'd0, real_m});
		cfg_write(REG_STATE_MODE, {31'd0, state_m});
	endtask

	// The result sink stalls for a random count after each taken word, or for
	// one long stretch when a test asks for it.
	initial begin : result_sink
		int pause;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				pause = rx_idle ? $urandom_range(0, 9) : 0;
				if (pause > 0) begin
					out_stall <= 1'b1;
					repeat (pause) @(posedge clk);
				end
				out_stall <= 1'b0;
				do @(posedge clk); while (!out_valid);
			end
		end
	end

	function automatic void check_field(string name, word_t want, word_t got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	// Every word taken on the result channel is matched against the oldest
	// prediction.
	always @(posedge clk) begin
		res_t want;
		if (out_valid && !out_stall) begin
			if (expected_grants.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
			end else begin
				want = expected_grants.pop_front();
				check_field("ok", word_t'(want.ok), word_t'(ok));
				check_field("granted_address", want.granted_address, granted_address);
				check_field("token_restore", want.token_restore, token_restore);
				check_field("token_check", want.token_check, token_check);
				check_field("peak_alignment", want.peak_alignment, peak_alignment);
				check_field("peak_offset", want.peak_offset, peak_offset);
				check_field("locked", word_t'(want.locked), word_t'(locked));
			end
			words_checked++;
		end
	end

	// Reset values: real mode on and a region of size zero, so only a
	// zero-sized allocation fits. Bad alignments, zero among them, are refused.
	task automatic test_reset_defaults();
		send_word(alloc_req(32'd0, 32'd1));
		send_word(alloc_req(32'd1, 32'd1));
		send_word(alloc_req(32'd0, 32'd0));
		send_word(alloc_req(32'd0, 32'd3));
		send_word(alloc_req(32'd0, 32'h8000_0000));
		send_word(release_req(32'd0, 32'd0));
		wait_idle();
	endtask

	// A small region: rounding, an exact fill, a request past the end, and an
	// alignment that the region base does not meet.
	task automatic test_region_fit();
		cfg_all(32'h0000_1000, 32'h0000_0100, 1'b1, 1'b0);
		send_word(alloc_req(32'h10, 32'd16));
		send_word(alloc_req(32'd1, 32'd1));
		send_word(alloc_req(32'd8, 32'd8));
		send_word(alloc_req(32'hE0, 32'd32));
		send_word(alloc_req(32'd1, 32'd1));
		send_word(release_req(32'd0, 32'h100));
		send_word(alloc_req(32'd0, 32'h2000));
		send_word(alloc_req(32'hFFFF_FFFF, 32'd1));
		wait_idle();
	endtask

	// Counting mode near the top of the offset range: the rounding add and the
	// size add each carry out once, and the largest offset is reached.
	task automatic test_offset_overflow();
		cfg_all(32'd0, 32'd0, 1'b0, 1'b1);
		send_word(release_req(32'hFFFF_FFF0, 32'd0));
		send_word(alloc_req(32'd0, 32'd32));
		send_word(alloc_req(32'hF, 32'd16));
		send_word(alloc_req(32'd1, 32'd1));
		send_word(release_req(32'd0, 32'hFFFF_FFFF));
		send_word(alloc_req(32'hFFFF_FFFF, 32'd1));
		send_word(release_req(32'd0, 32'hFFFF_FFFF));
		wait_idle();
	endtask

	task automatic random_phase(word_t base, word_t size, logic real_m, logic state_m,
			bit tx, bit rx, int count);
		cfg_all(base, size, real_m, state_m);
		tx_idle = tx;
		rx_idle = rx;
		repeat (count) send_word(random_request());
		wait_idle();
	endtask

	// Several register settings, the extremes among them, with and without
	// idling on each side.
	task automatic test_random_traffic();
		random_phase(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 130);
		random_phase(32'h4000_0000, 32'h0001_0000, 1'b1, 1'b1, 1'b1, 1'b1, 130);
		random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 130);
		random_phase($urandom() & 32'hFFFF_FF00, $urandom_range(32'h100, 32'h10_0000),
			1'b1, 1'b0, 1'b1, 1'b0, 130);
		random_phase(32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1, 130);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// The sink holds off for a long stretch while the source keeps offering
	// back to back, so the block fills and raises in_stall; then the source
	// pauses until everything has drained.
	task automatic test_backpressure();
		cfg_all(32'h0000_2000, 32'h0000_0800, 1'b1, 1'b0);
		tx_idle = 1'b0;
		rx_hold_cycles = 300;
		repeat (40) send_word(random_request());
		wait_idle();
		tx_idle = 1'b1;
	endtask

	// A mismatched release locks the allocator for good, so this runs last.
	// Allocations then fail, while a matching release still moves the top.
	task automatic test_lock();
		req_t r;
		send_word(release_req(32'd0, m_top + 1'b1));
		send_word(alloc_req(32'd0, 32'd1));
		send_word(release_req(32'd0, m_top));
		send_word(alloc_req(32'd4, 32'd4));
		repeat (50) begin
			r = random_request();
			if ($urandom_range(0, 1))
				r.check_offset = $urandom();
			send_word(r);
		end
		wait_idle();
	endtask

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		in_valid          <= 1'b0;
		kind              <= 1'b0;
		request_size      <= '0;
		request_alignment <= '0;
		restore_offset    <= '0;
		check_offset      <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_region_fit();
		test_offset_overflow();
		test_random_traffic();
		test_backpressure();
		test_lock();

		repeat (8) @(posedge clk);
		$display("covered %0d request words and %0d result words over %0d register writes,",
			words_sent, words_checked, reg_writes);
		$display("with region limits, offset carries, a long sink hold-off and the lock state");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
src/asa_pkg.sv
src/asa_regs.sv
src/asa_engine.sv
src/aligned_stack_allocator.sv
tb/sv/tb_aligned_stack_allocator.sv
